>>> hw/rtl/wmts_pkg.sv
// ----------------------------------------------------------------------------
// wmts_pkg: shared types and constants for the wire message threat screen
// Holds header offsets, rule constants, register indexes and the structs
// passed between the tracker, the config block and the verdict stage.
// ----------------------------------------------------------------------------
package wmts_pkg;

  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // compare width wide enough for 2*(len-21) and a 31-bit limit
  localparam int CMP_W = 34;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLAIMED_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZLIB_MIN_LEN  = 2'd2;

  localparam logic [15:0] SIZE_LIMIT_RST    = 16'd4096;
  localparam logic [30:0] CLAIMED_LIMIT_RST = 31'd5000;
  localparam logic [15:0] ZLIB_MIN_LEN_RST  = 16'd100;

  localparam logic [31:0] OPCODE_COMPRESSED = 32'd2012;
  localparam logic [7:0]  COMPRESS_ZLIB     = 8'd2;
  localparam int          HDR_FIXED         = 21;
  localparam int          HDR_MIN_LEN       = 16;
  localparam logic [15:0] ZLIB_MAGIC        = 16'h9C78;

  // header field offsets
  localparam int OFS_LENGTH = 0;
  localparam int OFS_OPCODE = 12;
  localparam int OFS_CLAIM  = 16;
  localparam int OFS_KIND   = 20;
  localparam int LEAD_LEN   = 2;

  // pattern history: "pin" + 'g', "$d" + 'b'
  localparam logic [23:0] PING_HEAD = 24'h70696E;
  localparam logic [7:0]  CHAR_G    = 8'h67;
  localparam logic [15:0] DB_HEAD   = 16'h2464;
  localparam logic [7:0]  CHAR_B    = 8'h62;

  typedef struct packed {
    logic [15:0] size_limit;
    logic [30:0] claimed_limit;
    logic [15:0] zlib_min_len;
  } wmts_cfg_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] len;
    logic [31:0]           header_length;
    logic [31:0]           header_opcode;
    logic [31:0]           size_claim;
    logic [7:0]            compress_kind;
    logic [15:0]           lead_bytes;
    logic                  pattern_seen;
  } wmts_msg_t;

endpackage

>>> hw/rtl/wire_message_threat_screen_unit.sv
// ----------------------------------------------------------------------------
// wire_message_threat_screen_unit: streaming message threat screen
// Takes a message one byte per transfer on the input channel (data_byte,
// last) and gives one transfer on the output channel per message: the
// suspicious flag, produced when the byte marked last has been processed.
// Bytes that are not last produce no output transfer.
// Throughput: one byte per cycle. The transfer edge loads the input register;
// the tracker and the rule logic feed the result register combinationally,
// and out_valid rises once the result of the last byte is loaded there.
// When the receiver stalls with a flag pending, bytes that are not last keep
// flowing; the next last byte waits in the input register until the pending
// flag is taken. Limits must be written on the cfg port while the unit is
// idle; the unit itself does not enforce this.
// Reset (rst, synchronous) empties both registers, clears the message state
// and loads the default limits.
// ----------------------------------------------------------------------------
module wire_message_threat_screen_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       data_byte,
  input  logic                             last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             suspicious,
  input  logic                             cfg_we,
  input  logic [wmts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wmts_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                in_full;
  logic [7:0]          in_byte;
  logic                in_last;
  logic                advance;
  wmts_pkg::wmts_cfg_t cfg;
  wmts_pkg::wmts_msg_t msg;

  // a last byte needs room in the result register
  assign advance  = in_full && (!in_last || !out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= data_byte;
      in_last <= last;
    end
  end

  wmts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wmts_track u_track (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .last      (in_last),
    .msg       (msg)
  );

  wmts_verdict u_verdict (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && in_last),
    .msg        (msg),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .suspicious (suspicious)
  );

endmodule

>>> hw/rtl/wmts_cfg.sv
// ----------------------------------------------------------------------------
// wmts_cfg: configuration registers
// Decodes the write port into the three limit registers.
// ----------------------------------------------------------------------------
module wmts_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [wmts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wmts_pkg::CFG_DATA_W-1:0]  cfg_data,
  output wmts_pkg::wmts_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_limit    <= wmts_pkg::SIZE_LIMIT_RST;
      cfg.claimed_limit <= wmts_pkg::CLAIMED_LIMIT_RST;
      cfg.zlib_min_len  <= wmts_pkg::ZLIB_MIN_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wmts_pkg::REG_SIZE_LIMIT:    cfg.size_limit    <= cfg_data[15:0];
        wmts_pkg::REG_CLAIMED_LIMIT: cfg.claimed_limit <= cfg_data[30:0];
        wmts_pkg::REG_ZLIB_MIN_LEN:  cfg.zlib_min_len  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/wmts_track.sv
// ----------------------------------------------------------------------------
// wmts_track: per-message tracking
// Byte counter, header captures, lead bytes and the pattern history.
// Presents the state as it stands after the current byte.
// ----------------------------------------------------------------------------
module wmts_track (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 last,
  output wmts_pkg::wmts_msg_t  msg
);

  localparam int CB = wmts_pkg::COUNT_BITS;

  logic [CB-1:0] byte_count, byte_count_next;
  logic [31:0]   header_length, header_length_next;
  logic [31:0]   header_opcode, header_opcode_next;
  logic [31:0]   size_claim, size_claim_next;
  logic [7:0]    compress_kind, compress_kind_next;
  logic [15:0]   lead_bytes, lead_bytes_next;
  logic [23:0]   recent_bytes, recent_bytes_next;
  logic          pattern_seen, pattern_seen_next;
  logic [1:0]    lane;

  assign lane = byte_count[1:0];

  always_comb begin
    header_length_next = header_length;
    header_opcode_next = header_opcode;
    size_claim_next    = size_claim;
    compress_kind_next = compress_kind;
    lead_bytes_next    = lead_bytes;

    // offsets 0, 12 and 16 are 4-aligned, so the low count bits pick the lane
    if (byte_count < CB'(wmts_pkg::OFS_LENGTH + 4)) begin
      header_length_next[{lane, 3'b000} +: 8] = data_byte;
    end else if (byte_count >= CB'(wmts_pkg::OFS_OPCODE) &&
                 byte_count <  CB'(wmts_pkg::OFS_OPCODE + 4)) begin
      header_opcode_next[{lane, 3'b000} +: 8] = data_byte;
    end else if (byte_count >= CB'(wmts_pkg::OFS_CLAIM) &&
                 byte_count <  CB'(wmts_pkg::OFS_CLAIM + 4)) begin
      size_claim_next[{lane, 3'b000} +: 8] = data_byte;
    end else if (byte_count == CB'(wmts_pkg::OFS_KIND)) begin
      compress_kind_next = data_byte;
    end
    if (byte_count < CB'(wmts_pkg::LEAD_LEN)) begin
      lead_bytes_next[{lane[0], 3'b000} +: 8] = data_byte;
    end

    pattern_seen_next = pattern_seen ||
                        (recent_bytes == wmts_pkg::PING_HEAD && data_byte == wmts_pkg::CHAR_G) ||
                        (recent_bytes[15:0] == wmts_pkg::DB_HEAD &&
                         data_byte == wmts_pkg::CHAR_B);
    recent_bytes_next = {recent_bytes[15:0], data_byte};

    byte_count_next = (byte_count != wmts_pkg::CNT_MAX) ? byte_count + 1'b1 : byte_count;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      byte_count    <= '0;
      header_length <= '0;
      header_opcode <= '0;
      size_claim    <= '0;
      compress_kind <= '0;
      lead_bytes    <= '0;
      recent_bytes  <= '0;
      pattern_seen  <= 1'b0;
    end else if (step) begin
      byte_count    <= byte_count_next;
      header_length <= header_length_next;
      header_opcode <= header_opcode_next;
      size_claim    <= size_claim_next;
      compress_kind <= compress_kind_next;
      lead_bytes    <= lead_bytes_next;
      recent_bytes  <= recent_bytes_next;
      pattern_seen  <= pattern_seen_next;
    end
  end

  assign msg.len           = byte_count_next;
  assign msg.header_length = header_length_next;
  assign msg.header_opcode = header_opcode_next;
  assign msg.size_claim    = size_claim_next;
  assign msg.compress_kind = compress_kind_next;
  assign msg.lead_bytes    = lead_bytes_next;
  assign msg.pattern_seen  = pattern_seen_next;

endmodule

>>> hw/rtl/wmts_verdict.sv
// ----------------------------------------------------------------------------
// wmts_verdict: threat rules and result register
// Evaluates the rules on the finished message and holds the flag until
// the output transfer.
// ----------------------------------------------------------------------------
module wmts_verdict (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  wmts_pkg::wmts_msg_t  msg,
  input  wmts_pkg::wmts_cfg_t  cfg,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 suspicious
);

  localparam int CW = wmts_pkg::CMP_W;

  logic [CW-1:0] len_w;
  logic [CW-1:0] twice;
  logic [CW-1:0] claim_w;
  logic [CW-1:0] hlen_w;
  logic          long_hdr;
  logic          claim_hit;
  logic          size_hit;
  logic          zlib_hit;
  logic          verdict;

  assign len_w    = CW'(msg.len);
  // only used when len > 21, so the subtraction never wraps there
  assign twice    = (len_w - CW'(wmts_pkg::HDR_FIXED)) << 1;
  assign claim_w  = CW'(msg.size_claim[30:0]);
  assign hlen_w   = CW'(msg.header_length[30:0]);
  assign long_hdr = len_w >= CW'(wmts_pkg::HDR_MIN_LEN);

  // negative header words never exceed a limit
  assign claim_hit = long_hdr &&
                     msg.header_opcode == wmts_pkg::OPCODE_COMPRESSED &&
                     len_w > CW'(wmts_pkg::HDR_FIXED) &&
                     msg.compress_kind == wmts_pkg::COMPRESS_ZLIB &&
                     !msg.size_claim[31] &&
                     (claim_w > twice || claim_w > CW'(cfg.claimed_limit));

  assign size_hit = long_hdr &&
                    ((!msg.header_length[31] && hlen_w > CW'(cfg.size_limit)) ||
                     len_w > CW'(cfg.size_limit));

  assign zlib_hit = len_w > CW'(cfg.zlib_min_len) && msg.lead_bytes == wmts_pkg::ZLIB_MAGIC;

  assign verdict = claim_hit || size_hit || zlib_hit || msg.pattern_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      suspicious <= verdict;
    end
  end

endmodule
